// ===== rtl/core/gig_pkg.sv =====
// Shared types, constants and codes of the geomipmap index generator.
package gig_pkg;

  localparam int PATCH_SIZE  = 33;
  localparam int LOD_LEVELS  = 5;

  localparam int CMD_W       = 3;
  localparam int LOD_W       = 3;
  localparam int CELL_W      = 5;
  localparam int VW          = 16;
  localparam int NUM_TRI     = 8;
  localparam int TRI_IDX_W   = $clog2(NUM_TRI);
  localparam int QUEUE_DEPTH = 2;

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_W   = PADDR_W - 2;
  localparam int REG_ROW_LENGTH = 0;

  localparam logic [VW-1:0] ROW_LENGTH_RESET = 16'd1025;
  localparam logic [VW-1:0] EDGE_POS = VW'(PATCH_SIZE - 1);

  localparam logic [CMD_W-1:0] CMD_NORTH  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EAST   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SOUTH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WEST   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CENTRE = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              coarse_neighbor;
    logic [LOD_W-1:0]  lod_level;
    logic [CELL_W-1:0] cell_row;
    logic [CELL_W-1:0] cell_col;
  } gig_req_t;

  typedef struct packed {
    logic [VW-1:0] vertex_first;
    logic [VW-1:0] vertex_second;
    logic [VW-1:0] vertex_third;
    logic          last_triangle;
  } gig_res_t;

  // One classified request: section, origin, spacing, half spacing, apex offsets and triangle mask.
  typedef struct packed {
    logic               centre;
    logic [1:0]         side;
    logic [VW-1:0]      a;
    logic [VW-1:0]      b;
    logic [VW-1:0]      s;
    logic [VW-1:0]      h;
    logic [VW-1:0]      d;
    logic [VW-1:0]      t1;
    logic [VW-1:0]      t2;
    logic [NUM_TRI-1:0] mask;
  } gig_desc_t;

  typedef struct packed {
    logic [VW-1:0] r0;
    logic [VW-1:0] c0;
    logic [VW-1:0] r1;
    logic [VW-1:0] c1;
    logic [VW-1:0] r2;
    logic [VW-1:0] c2;
    logic          last;
  } gig_coord_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } gig_qstat_t;

endpackage

// ===== rtl/core/geomipmap_index_generator_core.sv =====
// Top level of the geomipmap index generator: register port, front end, queue and back end.
//
// Each accepted request word names one cell of a terrain patch and produces that cell's
// triangles as result words, one triangle per clock cycle while res_stall is low, with
// last_triangle set on the final one. A border cell gives two triangles, a centre cell up
// to eight. Requests with no triangles (unknown section, level too high, cell beyond the
// patch, edge-only centre cell) are taken without entering the queue, unless it is full,
// and produce nothing. A request passes the queue, its triangles the coordinate and result
// registers. A two-word queue sits between the classifying front end and the triangle
// sequencer, so requests are taken while earlier ones are still being emitted; the
// sustained rate is set by the one-triangle-per-cycle sequencer and result register.
// row_length (reset 1025) is the vertex stride between rows; the user writes it through the
// register port only while the block is idle, which the block itself does not enforce.
module geomipmap_index_generator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  gig_pkg::gig_req_t              req,
  output logic                           res_valid,
  input  logic                           res_stall,
  output gig_pkg::gig_res_t              res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gig_pkg::PADDR_W-1:0]    paddr,
  input  logic [gig_pkg::PDATA_W-1:0]    pwdata,
  output logic [gig_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import gig_pkg::*;

  logic [VW-1:0]        row_length;
  logic                 reg_hit;
  gig_desc_t            front_desc;
  logic                 produce;
  gig_desc_t            head;
  gig_qstat_t           qstat;
  logic                 pop;
  gig_coord_t           coord;
  logic                 coord_valid;
  logic                 take;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_IDX_W'(REG_ROW_LENGTH));
  assign prdata  = reg_hit ? PDATA_W'(row_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      row_length <= pwdata[VW-1:0];
    end
  end

  assign req_stall = qstat.full;

  gig_front u_front (
    .req     (req),
    .desc    (front_desc),
    .produce (produce)
  );

  gig_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (req_valid && !qstat.full && produce),
    .wdata (front_desc),
    .pop   (pop),
    .rdata (head),
    .stat  (qstat)
  );

  gig_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (qstat.nonempty),
    .take        (take),
    .pop         (pop),
    .coord       (coord),
    .coord_valid (coord_valid)
  );

  gig_index u_index (
    .clk         (clk),
    .rst         (rst),
    .coord       (coord),
    .coord_valid (coord_valid),
    .row_length  (row_length),
    .res_stall   (res_stall),
    .res         (res),
    .res_valid   (res_valid),
    .take        (take)
  );

endmodule

// ===== rtl/core/gig_front.sv =====
// Front end: classifies a request and works out its cell geometry and triangle mask.
module gig_front (
  input  gig_pkg::gig_req_t  req,
  output gig_pkg::gig_desc_t desc,
  output logic               produce
);
  import gig_pkg::*;

  logic [3:0]    sh;
  logic [3:0]    sh_border;
  logic [VW-1:0] s;
  logic [VW-1:0] st;
  logic [VW-1:0] row;
  logic [VW-1:0] col;
  logic [VW-1:0] i;
  logic [VW-1:0] j;
  logic [VW-1:0] k;
  logic [VW-1:0] qd;
  logic          code_ok;
  logic          p_top;
  logic          p_right;
  logic          p_bottom;
  logic          p_left;

  always_comb begin
    sh        = {1'b0, req.lod_level} + 4'd1;
    sh_border = sh + {3'b000, req.coarse_neighbor};
    s         = VW'(1) << sh;
    st        = VW'(1) << sh_border;
    row       = VW'(req.cell_row);
    col       = VW'(req.cell_col);
    i         = row << sh;
    j         = col << sh;
    k         = row << sh_border;
    qd        = st >> 2;
    code_ok   = (req.cmd <= CMD_CENTRE) && ({1'b0, req.lod_level} < 4'(LOD_LEVELS));

    // A centre cell drops every pair of triangles that lies on the patch edge.
    p_top    = (i != '0);
    p_right  = ((j + s) != EDGE_POS);
    p_bottom = ((i + s) != EDGE_POS);
    p_left   = (j != '0);

    desc.centre = (req.cmd == CMD_CENTRE);
    desc.side   = req.cmd[1:0];
    if (req.cmd == CMD_CENTRE) begin
      desc.a  = i;
      desc.b  = j;
      desc.s  = s;
      desc.h  = s >> 1;
      desc.d  = '0;
      desc.t1 = '0;
      desc.t2 = '0;
      if ((i < EDGE_POS) && (j < EDGE_POS)) begin
        desc.mask = {p_left, p_left, p_bottom, p_bottom,
                     p_right, p_right, p_top, p_top};
      end else begin
        desc.mask = '0;
      end
    end else begin
      desc.a = k;
      desc.b = '0;
      desc.s = st;
      desc.h = st >> 1;
      if (req.coarse_neighbor) begin
        desc.d  = qd;
        desc.t1 = k + qd;
        desc.t2 = k + qd + (qd << 1);
      end else begin
        desc.d  = st >> 1;
        desc.t1 = k + (st >> 1);
        desc.t2 = k + (st >> 1);
      end
      desc.mask = (k < EDGE_POS) ? NUM_TRI'(2'b11) : '0;
    end
    if (!code_ok) begin
      desc.mask = '0;
    end
    produce = (desc.mask != '0);
  end

endmodule

// ===== rtl/core/gig_queue.sv =====
// Short queue of classified requests between the front and back ends.
module gig_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gig_pkg::gig_desc_t wdata,
  input  logic               pop,
  output gig_pkg::gig_desc_t rdata,
  output gig_pkg::gig_qstat_t stat
);
  import gig_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  gig_desc_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign stat.full     = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.nonempty = (count != '0);
  assign rdata         = entries[rd_ptr];
  assign do_push       = push && !stat.full;
  assign do_pop        = pop && stat.nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/gig_back.sv =====
// Back end: walks the triangle mask of the head request and registers one triangle's coordinates.
module gig_back (
  input  logic               clk,
  input  logic               rst,
  input  gig_pkg::gig_desc_t head,
  input  logic               head_valid,
  input  logic               take,
  output logic               pop,
  output gig_pkg::gig_coord_t coord,
  output logic               coord_valid
);
  import gig_pkg::*;

  logic                 started;
  logic [NUM_TRI-1:0]   rem;
  logic [NUM_TRI-1:0]   cur_mask;
  logic [NUM_TRI-1:0]   low_bit;
  logic [NUM_TRI-1:0]   rest;
  logic [TRI_IDX_W-1:0] n;
  logic                 emit;
  gig_coord_t           sel;
  logic [VW-1:0]        ah;
  logic [VW-1:0]        as_;
  logic [VW-1:0]        bh;
  logic [VW-1:0]        bs;
  logic [VW-1:0]        ed;

  always_comb begin
    cur_mask = started ? rem : head.mask;
    low_bit  = cur_mask & (~cur_mask + 1'b1);
    rest     = cur_mask & ~low_bit;
    n        = '0;
    for (int q = NUM_TRI - 1; q >= 0; q--) begin
      if (low_bit[q]) begin
        n = TRI_IDX_W'(q);
      end
    end
    emit = head_valid && (!coord_valid || take);
    pop  = emit && (rest == '0);
  end

  always_comb begin
    ah  = head.a + head.h;
    as_ = head.a + head.s;
    bh  = head.b + head.h;
    bs  = head.b + head.s;
    ed  = EDGE_POS - head.d;
    sel = '0;
    sel.last = (rest == '0);
    if (head.centre) begin
      unique case (n)
        3'd0: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
              {head.a, head.b, head.a, bh, ah, bh};
        3'd1: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
              {head.a, bh, head.a, bs, ah, bh};
        3'd2: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
              {head.a, bs, ah, bs, ah, bh};
        3'd3: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
              {ah, bh, ah, bs, as_, bs};
        3'd4: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
              {ah, bh, as_, bh, as_, head.b};
        3'd5: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
              {ah, bh, as_, bs, as_, bh};
        3'd6: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
              {ah, head.b, ah, bh, as_, head.b};
        default: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
              {head.a, head.b, ah, bh, ah, head.b};
      endcase
    end else begin
      // Border cells: a is the start offset along the edge, s and h the stitch spacing.
      unique case ({head.side, n[0]})
        3'b000: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
                {VW'(0), head.a, VW'(0), ah, head.d, head.t1};
        3'b001: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
                {VW'(0), ah, VW'(0), as_, head.d, head.t2};
        3'b010: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
                {head.a, EDGE_POS, ah, EDGE_POS, head.t1, ed};
        3'b011: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
                {ah, EDGE_POS, as_, EDGE_POS, head.t2, ed};
        3'b100: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
                {EDGE_POS, as_, EDGE_POS, ah, ed, head.t2};
        3'b101: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
                {EDGE_POS, ah, EDGE_POS, head.a, ed, head.t1};
        3'b110: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
                {as_, VW'(0), ah, VW'(0), head.t2, head.d};
        default: {sel.r0, sel.c0, sel.r1, sel.c1, sel.r2, sel.c2} =
                {ah, VW'(0), head.a, VW'(0), head.t1, head.d};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      coord <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      rem         <= '0;
      coord_valid <= 1'b0;
    end else begin
      if (!coord_valid || take) begin
        coord_valid <= emit;
      end
      if (emit) begin
        started <= (rest != '0);
        rem     <= rest;
      end
    end
  end

endmodule

// ===== rtl/core/gig_index.sv =====
// Index stage: turns row and column coordinates into wrapped vertex indices in the output register.
module gig_index (
  input  logic                clk,
  input  logic                rst,
  input  gig_pkg::gig_coord_t coord,
  input  logic                coord_valid,
  input  logic [15:0]         row_length,
  input  logic                res_stall,
  output gig_pkg::gig_res_t   res,
  output logic                res_valid,
  output logic                take
);
  import gig_pkg::*;

  logic [2*VW-1:0] p0;
  logic [2*VW-1:0] p1;
  logic [2*VW-1:0] p2;
  gig_res_t        res_next;

  always_comb begin
    p0 = coord.r0 * row_length;
    p1 = coord.r1 * row_length;
    p2 = coord.r2 * row_length;
    res_next.vertex_first  = p0[VW-1:0] + coord.c0;
    res_next.vertex_second = p1[VW-1:0] + coord.c1;
    res_next.vertex_third  = p2[VW-1:0] + coord.c2;
    res_next.last_triangle = coord.last;
    take = !res_valid || !res_stall;
  end

  always_ff @(posedge clk) begin
    if (take && coord_valid) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= coord_valid;
    end
  end

endmodule

// ===== rtl/core/gig_checker.sv =====
// Port-level assertions for the geomipmap index generator, bound to the top level.
module gig_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input gig_pkg::gig_req_t           req,
  input logic                        res_valid,
  input logic                        res_stall,
  input gig_pkg::gig_res_t           res,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [gig_pkg::PADDR_W-1:0] paddr,
  input logic [gig_pkg::PDATA_W-1:0] pwdata,
  input logic [gig_pkg::PDATA_W-1:0] prdata,
  input logic                        pready
);
  import gig_pkg::*;

  // A stalled result word holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result word changed while stalled");

  // Reset empties the queue and the result register.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && !req_stall)
    else $error("block not cleared by reset");

  // The triangles of one request leave back to back.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !res.last_triangle |=> res_valid)
    else $error("gap inside the triangles of one request");

  // A write of row_length reads back on the next cycle.
  a_reg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready &&
    (paddr[PADDR_W-1:2] == REG_IDX_W'(REG_ROW_LENGTH))
    |=> (paddr[PADDR_W-1:2] != REG_IDX_W'(REG_ROW_LENGTH)) ||
        (prdata[VW-1:0] == $past(pwdata[VW-1:0])))
    else $error("row_length readback mismatch");

endmodule

bind geomipmap_index_generator_core gig_checker u_gig_checker (.*);
